// ===== src/gcdb_pkg.sv =====
// Shared types, constants and tables for the great-circle distance and bearing block.
package gcdb_pkg;

  localparam int N_STAGES = 24;
  localparam int SQRT_STAGES = 31;
  localparam int XY_W = 34;
  localparam int Z_W = 34;
  localparam int VX_W = 56;
  localparam int SQ_W = 62;
  localparam int ROT_LANES = 5;

  localparam logic [22:0] RADIUS_RESET = 23'd6371004;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = XY_W'(652032874);
  localparam logic [30:0] PI_Q29 = 31'd1686629713;
  localparam logic [30:0] TURN_OUT = 31'd1509949440;
  localparam logic signed [63:0] ONE_Q60 = 64'sh1000000000000000;
  localparam logic [31:0] DIV45_MUL = 32'd3054198966;
  localparam logic [31:0] DIV45_OFF = 32'd1509949440;
  localparam logic [31:0] DIV45 = 32'd45;

  localparam logic [31:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   neg;
  } rot_t;

  typedef struct packed {
    logic signed [VX_W-1:0] x;
    logic signed [VX_W-1:0] y;
    logic [31:0]            z;
    logic                   hold;
  } vec_t;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] r;
  } sqrt_t;

  // Fraction of a turn unit contributed by the remainder of a division by 45.
  function automatic logic [6:0] turn_frac(input logic [5:0] r);
    logic [6:0] f;
    case (r)
      6'd0: f = 7'd0;     6'd1: f = 7'd3;     6'd2: f = 7'd6;     6'd3: f = 7'd9;
      6'd4: f = 7'd11;    6'd5: f = 7'd14;    6'd6: f = 7'd17;    6'd7: f = 7'd20;
      6'd8: f = 7'd23;    6'd9: f = 7'd26;    6'd10: f = 7'd28;   6'd11: f = 7'd31;
      6'd12: f = 7'd34;   6'd13: f = 7'd37;   6'd14: f = 7'd40;   6'd15: f = 7'd43;
      6'd16: f = 7'd46;   6'd17: f = 7'd48;   6'd18: f = 7'd51;   6'd19: f = 7'd54;
      6'd20: f = 7'd57;   6'd21: f = 7'd60;   6'd22: f = 7'd63;   6'd23: f = 7'd65;
      6'd24: f = 7'd68;   6'd25: f = 7'd71;   6'd26: f = 7'd74;   6'd27: f = 7'd77;
      6'd28: f = 7'd80;   6'd29: f = 7'd82;   6'd30: f = 7'd85;   6'd31: f = 7'd88;
      6'd32: f = 7'd91;   6'd33: f = 7'd94;   6'd34: f = 7'd97;   6'd35: f = 7'd100;
      6'd36: f = 7'd102;  6'd37: f = 7'd105;  6'd38: f = 7'd108;  6'd39: f = 7'd111;
      6'd40: f = 7'd114;  6'd41: f = 7'd117;  6'd42: f = 7'd119;  6'd43: f = 7'd122;
      6'd44: f = 7'd125;
      default: f = 7'd0;
    endcase
    return f;
  endfunction

  // Prepares a vector for the vectoring chain, handling the degenerate cases.
  function automatic vec_t vec_init(input logic signed [VX_W-1:0] x,
                                    input logic signed [VX_W-1:0] y);
    vec_t o;
    o.x = x;
    o.y = y;
    o.z = '0;
    o.hold = 1'b0;
    if (x == '0 && y == '0) begin
      o.hold = 1'b1;
    end else begin
      if (x < 0) begin
        o.x = -x;
        o.y = -y;
        o.z = 32'h80000000;
      end
      if (o.y == '0) begin
        o.hold = 1'b1;
      end
    end
    return o;
  endfunction

endpackage

// ===== src/great_circle_distance_bearing_top.sv =====
// Top level of the great-circle distance and initial bearing pipeline.
// The block takes one point pair in every clock cycle and returns distance and
// bearing for each pair with done high for a single cycle; the receiver must
// take each transfer then. Each pair passes through the rotation CORDIC chain,
// the 31-step square root chain and the vectoring CORDIC chain in series, with
// 24 CORDIC stages in each CORDIC chain; busy is high only during reset.
module great_circle_distance_bearing_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [22:0]        cfg_wdata,
  input  logic signed [29:0] from_lat,
  input  logic signed [30:0] from_lon,
  input  logic signed [29:0] to_lat,
  input  logic signed [30:0] to_lon,
  output logic               done,
  output logic [28:0]        distance,
  output logic [30:0]        bearing
);

  localparam int N = gcdb_pkg::N_STAGES;
  localparam int SQ = gcdb_pkg::SQRT_STAGES;
  localparam int LAT = 43 + 2 * N;
  localparam int L_LAT1 = 0;
  localparam int L_LAT2 = 1;
  localparam int L_HLAT = 2;
  localparam int L_HLON = 3;
  localparam int L_DLON = 4;

  logic [22:0]     radius;
  logic [LAT-2:0]  vld;
  logic [LAT-5:0]  coin_pipe;

  logic [31:0] u_in [4];
  logic [31:0] c_u [4];
  logic [63:0] c_p [4];
  logic [26:0] q_s2 [4];
  logic [6:0]  r_s2 [4];
  logic [26:0] q_fix [4];
  logic [6:0]  r_fix [4];
  logic [31:0] turn [4];

  logic [31:0] dlat, dlon;
  logic [31:0] ang [gcdb_pkg::ROT_LANES];
  logic [31:0] ang_f [gcdb_pkg::ROT_LANES];
  logic [31:0] fold [gcdb_pkg::ROT_LANES];
  gcdb_pkg::rot_t rot_c [gcdb_pkg::ROT_LANES][N+1];

  logic signed [31:0] sn_v [gcdb_pkg::ROT_LANES];
  logic signed [31:0] cs_v [gcdb_pkg::ROT_LANES];

  logic signed [63:0] m_sh, m_cc, m_nn, m_sdc2, m_c1s2, m_s1c2;
  logic signed [31:0] cd_1, cd_2;
  logic signed [31:0] t_cc, t_nn, t_s1c2;
  logic signed [63:0] m_sh_2, m_sdc2_2, m_c1s2_2;
  logic signed [63:0] m_prod, m_prod2, m_sh_3, m_sdc2_3, m_c1s2_3;
  logic signed [63:0] a_sum;
  logic [60:0]        a_q;
  logic signed [gcdb_pkg::VX_W-1:0] bx_q, by_q;

  gcdb_pkg::sqrt_t sq_c [2][SQ+1];
  gcdb_pkg::vec_t  bv_c [N+1];
  gcdb_pkg::vec_t  dv_c [N+1];
  logic [31:0]     bt_dly [SQ];

  logic signed [31:0] h_s;
  logic [30:0]        h_c;
  logic [54:0]        p_q;
  logic [30:0]        bb_q, bw_q;
  logic [58:0]        mh_q;
  logic [57:0]        ml_q;
  logic [37:0]        bm;
  logic [59:0]        dsum;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= gcdb_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      radius <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[LAT-3:0], start & ~busy};
      done <= vld[LAT-2];
    end
  end

  // Angle conversion: floor((128 v + 22) / 45) through a reciprocal multiply.
  assign u_in[0] = 32'(from_lat) + gcdb_pkg::DIV45_OFF;
  assign u_in[1] = 32'(from_lon) + gcdb_pkg::DIV45_OFF;
  assign u_in[2] = 32'(to_lat) + gcdb_pkg::DIV45_OFF;
  assign u_in[3] = 32'(to_lon) + gcdb_pkg::DIV45_OFF;

  for (genvar k = 0; k < 4; k++) begin : g_conv
    always_comb begin
      if (r_s2[k] >= 7'd45) begin
        q_fix[k] = q_s2[k] + 27'd1;
        r_fix[k] = r_s2[k] - 7'd45;
      end else begin
        q_fix[k] = q_s2[k];
        r_fix[k] = r_s2[k];
      end
    end

    always_ff @(posedge clk) begin
      c_u[k]  <= u_in[k];
      c_p[k]  <= {32'b0, u_in[k]} * {32'b0, gcdb_pkg::DIV45_MUL};
      q_s2[k] <= c_p[k][63:37];
      r_s2[k] <= 7'(c_u[k] - 32'(c_p[k][63:37]) * gcdb_pkg::DIV45);
      turn[k] <= {q_fix[k][24:0], 7'b0} + 32'(gcdb_pkg::turn_frac(r_fix[k][5:0]));
    end
  end

  assign dlat = turn[2] - turn[0];
  assign dlon = turn[3] - turn[1];
  assign ang[L_LAT1] = turn[0];
  assign ang[L_LAT2] = turn[2];
  assign ang[L_HLAT] = {dlat[31], dlat[31:1]};
  assign ang[L_HLON] = {dlon[31], dlon[31:1]};
  assign ang[L_DLON] = dlon;

  always_ff @(posedge clk) begin
    coin_pipe <= {coin_pipe[LAT-6:0], (dlat == '0) && (dlon == '0)};
  end

  for (genvar g = 0; g < gcdb_pkg::ROT_LANES; g++) begin : g_rot
    assign fold[g]  = ang[g] + 32'h40000000;
    assign ang_f[g] = fold[g][31] ? (ang[g] ^ 32'h80000000) : ang[g];

    always_ff @(posedge clk) begin
      rot_c[g][0].x   <= gcdb_pkg::GAIN_Q30;
      rot_c[g][0].y   <= '0;
      rot_c[g][0].z   <= gcdb_pkg::Z_W'(signed'(ang_f[g]));
      rot_c[g][0].neg <= fold[g][31];
    end

    for (genvar s = 0; s < N; s++) begin : g_cell
      gcdb_rot_cell u_cell (
        .clk  (clk),
        .idx  (5'(s)),
        .din  (rot_c[g][s]),
        .dout (rot_c[g][s+1])
      );
    end

    assign sn_v[g] = rot_c[g][N].neg ? 32'(-rot_c[g][N].y) : 32'(rot_c[g][N].y);
    assign cs_v[g] = rot_c[g][N].neg ? 32'(-rot_c[g][N].x) : 32'(rot_c[g][N].x);
  end

  always_ff @(posedge clk) begin
    m_sh   <= sn_v[L_HLAT] * sn_v[L_HLAT];
    m_cc   <= cs_v[L_LAT1] * cs_v[L_LAT2];
    m_nn   <= sn_v[L_HLON] * sn_v[L_HLON];
    m_sdc2 <= sn_v[L_DLON] * cs_v[L_LAT2];
    m_c1s2 <= cs_v[L_LAT1] * sn_v[L_LAT2];
    m_s1c2 <= sn_v[L_LAT1] * cs_v[L_LAT2];
    cd_1   <= cs_v[L_DLON];

    t_cc     <= 32'(m_cc >>> 30);
    t_nn     <= 32'(m_nn >>> 30);
    t_s1c2   <= 32'(m_s1c2 >>> 30);
    cd_2     <= cd_1;
    m_sh_2   <= m_sh;
    m_sdc2_2 <= m_sdc2;
    m_c1s2_2 <= m_c1s2;

    m_prod   <= t_cc * t_nn;
    m_prod2  <= t_s1c2 * cd_2;
    m_sh_3   <= m_sh_2;
    m_sdc2_3 <= m_sdc2_2;
    m_c1s2_3 <= m_c1s2_2;
  end

  assign a_sum = m_sh_3 + m_prod;

  always_ff @(posedge clk) begin
    if (a_sum < 0) begin
      a_q <= '0;
    end else if (a_sum > gcdb_pkg::ONE_Q60) begin
      a_q <= 61'(gcdb_pkg::ONE_Q60);
    end else begin
      a_q <= 61'(a_sum);
    end
    bx_q <= gcdb_pkg::VX_W'((m_c1s2_3 - m_prod2) >>> 10);
    by_q <= gcdb_pkg::VX_W'(m_sdc2_3 >>> 10);
  end

  assign sq_c[0][0].v = gcdb_pkg::SQ_W'(a_q);
  assign sq_c[0][0].r = '0;
  assign sq_c[1][0].v = gcdb_pkg::SQ_W'(gcdb_pkg::ONE_Q60) - gcdb_pkg::SQ_W'(a_q);
  assign sq_c[1][0].r = '0;

  for (genvar j = 0; j < 2; j++) begin : g_sqrt
    for (genvar s = 0; s < SQ; s++) begin : g_cell
      gcdb_sqrt_cell u_cell (
        .clk  (clk),
        .idx  (5'(s)),
        .din  (sq_c[j][s]),
        .dout (sq_c[j][s+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    bv_c[0] <= gcdb_pkg::vec_init(bx_q, by_q);
    dv_c[0] <= gcdb_pkg::vec_init(gcdb_pkg::VX_W'(sq_c[1][SQ].r),
                                  gcdb_pkg::VX_W'(sq_c[0][SQ].r));
  end

  for (genvar s = 0; s < N; s++) begin : g_vec
    gcdb_vec_cell u_bcell (
      .clk  (clk),
      .idx  (5'(s)),
      .din  (bv_c[s]),
      .dout (bv_c[s+1])
    );
    gcdb_vec_cell u_dcell (
      .clk  (clk),
      .idx  (5'(s)),
      .din  (dv_c[s]),
      .dout (dv_c[s+1])
    );
  end

  always_ff @(posedge clk) begin
    bt_dly[0] <= bv_c[N].z;
    for (int k = 1; k < SQ; k++) begin
      bt_dly[k] <= bt_dly[k-1];
    end
  end

  assign h_s = signed'(dv_c[N].z);
  assign bm  = 38'(bt_dly[SQ-1]) * 38'd45 + 38'd64;

  always_comb begin
    if (h_s < 0) begin
      h_c = '0;
    end else if (h_s > 32'sh40000000) begin
      h_c = 31'h40000000;
    end else begin
      h_c = 31'(h_s);
    end
  end

  always_ff @(posedge clk) begin
    p_q  <= 55'(radius) * 55'({h_c, 1'b0});
    bb_q <= bm[37:7];
    mh_q <= 59'(p_q[54:27]) * 59'(gcdb_pkg::PI_Q29);
    ml_q <= 58'(p_q[26:0]) * 58'(gcdb_pkg::PI_Q29);
    bw_q <= (bb_q >= gcdb_pkg::TURN_OUT) ? bb_q - gcdb_pkg::TURN_OUT : bb_q;
  end

  assign dsum = 60'(mh_q) + 60'(ml_q >> 27) + (60'(1) << 28);

  always_ff @(posedge clk) begin
    if (coin_pipe[LAT-5]) begin
      distance <= '0;
      bearing  <= '0;
    end else begin
      distance <= dsum[57:29];
      bearing  <= bw_q;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) rst |=> !done)
    else $error("result transfer right after reset");
  assert property (@(posedge clk) disable iff (rst)
    vld[N+7] |-> (a_q <= 61'(gcdb_pkg::ONE_Q60)))
    else $error("haversine term outside the unit range");
  assert property (@(posedge clk) disable iff (rst)
    vld[N+38] |-> ((sq_c[0][SQ].r <= (gcdb_pkg::SQ_W'(1) << 30)) &&
                   (sq_c[1][SQ].r <= (gcdb_pkg::SQ_W'(1) << 30))))
    else $error("square root result above one");
  assert property (@(posedge clk) disable iff (rst)
    done |-> (bearing < gcdb_pkg::TURN_OUT))
    else $error("bearing not below a full turn");
`endif

endmodule

// ===== src/gcdb_rot_cell.sv =====
// One rotation-mode CORDIC cell.
module gcdb_rot_cell (
  input  logic            clk,
  input  logic [4:0]      idx,
  input  gcdb_pkg::rot_t  din,
  output gcdb_pkg::rot_t  dout
);

  logic signed [gcdb_pkg::XY_W-1:0] xs;
  logic signed [gcdb_pkg::XY_W-1:0] ys;
  logic signed [gcdb_pkg::Z_W-1:0]  ang;

  assign xs  = din.x >>> idx;
  assign ys  = din.y >>> idx;
  assign ang = gcdb_pkg::Z_W'(gcdb_pkg::ATAN_TURN[idx]);

  always_ff @(posedge clk) begin
    if (!din.z[gcdb_pkg::Z_W-1]) begin
      dout.x <= din.x - ys;
      dout.y <= din.y + xs;
      dout.z <= din.z - ang;
    end else begin
      dout.x <= din.x + ys;
      dout.y <= din.y - xs;
      dout.z <= din.z + ang;
    end
    dout.neg <= din.neg;
  end

endmodule

// ===== src/gcdb_vec_cell.sv =====
// One vectoring-mode CORDIC cell.
module gcdb_vec_cell (
  input  logic            clk,
  input  logic [4:0]      idx,
  input  gcdb_pkg::vec_t  din,
  output gcdb_pkg::vec_t  dout
);

  logic signed [gcdb_pkg::VX_W-1:0] xs;
  logic signed [gcdb_pkg::VX_W-1:0] ys;

  assign xs = din.x >>> idx;
  assign ys = din.y >>> idx;

  always_ff @(posedge clk) begin
    if (din.hold) begin
      dout.x <= din.x;
      dout.y <= din.y;
      dout.z <= din.z;
    end else if (!din.y[gcdb_pkg::VX_W-1]) begin
      dout.x <= din.x + ys;
      dout.y <= din.y - xs;
      dout.z <= din.z + gcdb_pkg::ATAN_TURN[idx];
    end else begin
      dout.x <= din.x - ys;
      dout.y <= din.y + xs;
      dout.z <= din.z - gcdb_pkg::ATAN_TURN[idx];
    end
    dout.hold <= din.hold;
  end

endmodule

// ===== src/gcdb_sqrt_cell.sv =====
// One digit step of the integer square root.
module gcdb_sqrt_cell (
  input  logic             clk,
  input  logic [4:0]       idx,
  input  gcdb_pkg::sqrt_t  din,
  output gcdb_pkg::sqrt_t  dout
);

  logic [5:0]                  sh;
  logic [gcdb_pkg::SQ_W-1:0]   bitv;
  logic [gcdb_pkg::SQ_W-1:0]   trial;

  assign sh    = 6'd60 - {idx, 1'b0};
  assign bitv  = gcdb_pkg::SQ_W'(1) << sh;
  assign trial = din.r + bitv;

  always_ff @(posedge clk) begin
    if (din.v >= trial) begin
      dout.v <= din.v - trial;
      dout.r <= (din.r >> 1) + bitv;
    end else begin
      dout.v <= din.v;
      dout.r <= din.r >> 1;
    end
  end

endmodule
